/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and sizes for the double-ended queue: word and command
// formats, cell-to-cell data and control, and the back-word select tree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 1024;
    localparam int WORD_W     = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int COUNT_W    = 11;
    localparam int GROUP_SIZE = 32;
    localparam int GROUP_CNT  = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]   front_word;
        logic signed [31:0]   back_word;
        logic [COUNT_W-1:0]   count;
        logic                 is_empty;
        t_status              status;
    } t_out_item;

    // word held by one cell, with its occupancy flag
    typedef struct packed {
        logic                     valid;
        logic signed [WORD_W-1:0] word;
    } t_cell_data;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic                     en;
        t_cmd                     cmd;
        logic signed [WORD_W-1:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell
// One position of the queue row. Shifts toward the back on a front push,
// toward the front on a front pop, and acts locally at the back boundary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_cell import deq_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cell_ctl                i_ctl,
    input  wire t_cell_data               i_left,
    input  wire t_cell_data               i_right,
    output t_cell_data                    o_data,
    output logic signed [WORD_W-1:0]      o_last_word
);

    logic                     r_valid;
    logic signed [WORD_W-1:0] r_word;
    logic                     n_valid;
    logic signed [WORD_W-1:0] n_word;

    always_comb begin
        n_valid = r_valid;
        n_word  = r_word;
        if (i_ctl.en) begin
            case (i_ctl.cmd)
                CMD_PUSH_FRONT: begin
                    n_valid = i_left.valid;
                    n_word  = i_left.word;
                end
                CMD_PUSH_BACK: begin
                    // first empty cell takes the word
                    if (!r_valid && i_left.valid) begin
                        n_valid = 1'b1;
                        n_word  = i_ctl.value;
                    end
                end
                CMD_POP_FRONT: begin
                    n_valid = i_right.valid;
                    n_word  = i_right.word;
                end
                CMD_POP_BACK: begin
                    if (r_valid && !i_right.valid) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_data.valid = r_valid;
    assign o_data.word  = r_word;

    // only the last occupied cell offers its word to the back select
    assign o_last_word = (r_valid && !i_right.valid) ? r_word : '0;

endmodule

`default_nettype wire

/* rtl/deq_group.sv */
// ----------------------------------------------------------------------------
// deq_group
// First level of the back-word select: registered OR over one group of
// cells, at most one of which offers a nonzero word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_group import deq_pkg::*; (
    input  wire logic                                i_clk,
    input  wire logic [GROUP_SIZE-1:0][WORD_W-1:0]   i_words,
    output logic [WORD_W-1:0]                        o_or
);

    logic [WORD_W-1:0] r_or;
    logic [WORD_W-1:0] n_or;

    always_comb begin
        n_or = '0;
        for (int k = 0; k < GROUP_SIZE; k++) begin
            n_or = n_or | i_words[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_or <= n_or;
    end

    assign o_or = r_or;

endmodule

`default_nettype wire

/* rtl/double_ended_queue_core.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 32-bit words kept in a row of cells, front at
// cell zero. Each command word returns front, back, count, empty and status.
// ----------------------------------------------------------------------------
//  channel | valid         | stall         | payload
//  --------+---------------+---------------+------------------------
//  command | i_in_valid    | o_in_stall    | i_in_item  (t_in_item)
//  result  | o_out_valid   | i_out_stall   | o_out_item (t_out_item)
//
//  a command reaches its result through the cell row update, the group OR of
//  the back-word candidates and the final OR into the result register
//  one command is in flight at a time; the next is taken once the result
//  register has been loaded, while that result may still wait to be taken
//  reset clears the cell valid flags and the count; no clearing pass
//  a stalled result holds in the output register and blocks the next load
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core import deq_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROUP,
        S_FINAL
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    t_status           r_status;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    t_status           n_status;
    logic [CNT_W-1:0]  n_count;
    logic              w_load;
    logic [WORD_W-1:0] w_back;
    t_cell_ctl         w_ctl;

    t_cell_data                               w_data  [DEPTH];
    logic [GROUP_CNT*GROUP_SIZE-1:0][WORD_W-1:0] w_last;
    logic [GROUP_CNT-1:0][WORD_W-1:0]         w_grp;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    always_comb begin
        n_status = ST_DONE;
        n_count  = r_count;
        case (i_in_item.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    assign w_ctl.en    = w_accept && (n_status == ST_DONE);
    assign w_ctl.cmd   = i_in_item.cmd;
    assign w_ctl.value = i_in_item.value;

    // cell row; the front neighbor of cell zero is the incoming word
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_data w_left;
        t_cell_data w_right;
        logic signed [WORD_W-1:0] w_cand;

        if (g == 0) begin : g_head
            assign w_left.valid = 1'b1;
            assign w_left.word  = i_in_item.value;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right.valid = 1'b0;
            assign w_right.word  = '0;
        end else begin : g_body
            assign w_right = w_data[g+1];
        end

        deq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_data      (w_data[g]),
            .o_last_word (w_cand)
        );

        assign w_last[g] = w_cand;
    end

    for (genvar p = DEPTH; p < GROUP_CNT * GROUP_SIZE; p++) begin : g_pad
        assign w_last[p] = '0;
    end

    for (genvar q = 0; q < GROUP_CNT; q++) begin : g_grp
        deq_group u_group (
            .i_clk   (i_clk),
            .i_words (w_last[q*GROUP_SIZE +: GROUP_SIZE]),
            .o_or    (w_grp[q])
        );
    end

    always_comb begin
        w_back = '0;
        for (int k = 0; k < GROUP_CNT; k++) begin
            w_back = w_back | w_grp[k];
        end
    end

    assign w_load = (r_state == S_FINAL) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_status    <= ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count  <= n_count;
                        r_status <= n_status;
                        r_state  <= S_GROUP;
                    end
                end
                S_GROUP: begin
                    r_state <= S_FINAL;
                end
                S_FINAL: begin
                    if (w_load) begin
                        r_out_valid           <= 1'b1;
                        r_out_item.front_word <= w_data[0].valid ? w_data[0].word : '0;
                        r_out_item.back_word  <= w_back;
                        r_out_item.count      <= COUNT_W'(r_count);
                        r_out_item.is_empty   <= (r_count == '0);
                        r_out_item.status     <= r_status;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // count and the head cell agree on emptiness
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == !w_data[0].valid)
        else $error("count and head cell disagree on empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count above depth");

    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GROUP && r_status == ST_PUSH_FULL) |-> (r_count == CNT_W'(DEPTH)))
        else $error("push refused while not full");

    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_in_stall && $changed(r_state)))
        else $error("second word taken while one is in flight");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out_item))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire
